[design/cfs_pkg.sv]
// cfs_pkg: sizes, codes and beat types shared by the call frame stack modules
// no dependencies
package cfs_pkg;

    // capacity of the design
    localparam int STORE_WORDS = 1024;
    localparam int MAX_NESTING = 64;
    localparam int WORD_BITS   = 32;

    // fixed field widths of the beats
    localparam int SLOT_W  = 10;
    localparam int WORD_W  = 32;
    localparam int FRAME_W = 11;

    // derived widths
    localparam int STORE_AW = $clog2(STORE_WORDS);
    localparam int BASE_W   = $clog2(STORE_WORDS + 1);
    localparam int RET_AW   = $clog2(MAX_NESTING);
    localparam int CNT_W    = $clog2(MAX_NESTING + 1);
    localparam int SUM_W    = ((BASE_W > FRAME_W) ? BASE_W : FRAME_W) + 1;

    typedef enum logic [1:0] {
        FN_READ,
        FN_WRITE,
        FN_OPEN,
        FN_CLOSE
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_NO_FIT,
        STAT_BEYOND,
        STAT_RET_FULL
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_POP
    } state_t;

    typedef struct packed {
        func_t              func;
        logic [SLOT_W-1:0]  slot_index;
        logic [WORD_W-1:0]  write_word;
        logic [FRAME_W-1:0] frame_words;
    } in_beat_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_word;
        logic              is_empty;
        status_t           status;
    } out_beat_t;

    // request to the word store
    typedef struct packed {
        logic                 we;
        logic                 re;
        logic [STORE_AW-1:0]  addr;
        logic [WORD_BITS-1:0] wdata;
    } store_req_t;

    // request to the return stack
    typedef struct packed {
        logic              we;
        logic              re;
        logic [RET_AW-1:0] addr;
        logic [BASE_W-1:0] wdata;
    } ret_req_t;

endpackage

[design/cfs_ram.sv]
// cfs_ram: single-port synchronous ram, registered read
// no dependencies
module cfs_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/cfs_ctrl.sv]
// cfs_ctrl: frame registers, sequencer and result register of the call frame stack
// depends on cfs_pkg
module cfs_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cfs_pkg::in_beat_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cfs_pkg::out_beat_t            out_data,
    output cfs_pkg::store_req_t           store_req,
    input  logic [cfs_pkg::WORD_BITS-1:0] store_rdata,
    output cfs_pkg::ret_req_t             ret_req,
    input  logic [cfs_pkg::BASE_W-1:0]    ret_rdata
);

    cfs_pkg::state_t                state_reg, state_next;
    logic [cfs_pkg::BASE_W-1:0]     base_reg, base_next;
    logic [cfs_pkg::BASE_W-1:0]     len_reg, len_next;
    logic [cfs_pkg::CNT_W-1:0]      count_reg, count_next;
    logic                           out_valid_reg, out_valid_next;
    cfs_pkg::out_beat_t             out_data_reg, out_data_next;

    logic                           accept;
    logic [cfs_pkg::SUM_W-1:0]      addr_sum;
    logic [cfs_pkg::SUM_W-1:0]      next_base;
    logic [cfs_pkg::SUM_W-1:0]      open_end;
    logic                           beyond;
    logic                           no_fit;
    logic [cfs_pkg::CNT_W-1:0]      count_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cfs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            len_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            base_reg      <= base_next;
            len_reg       <= len_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        len_next       = len_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        store_req      = '0;
        ret_req        = '0;

        in_ready = (state_reg == cfs_pkg::ST_IDLE) && (!out_valid_reg || out_ready);
        accept   = in_valid && in_ready;

        addr_sum  = cfs_pkg::SUM_W'(base_reg) + cfs_pkg::SUM_W'(in_data.slot_index);
        beyond    = addr_sum >= cfs_pkg::SUM_W'(cfs_pkg::STORE_WORDS);
        next_base = cfs_pkg::SUM_W'(base_reg) + cfs_pkg::SUM_W'(len_reg);
        open_end  = next_base + cfs_pkg::SUM_W'(in_data.frame_words);
        no_fit    = open_end > cfs_pkg::SUM_W'(cfs_pkg::STORE_WORDS);
        count_dec = count_reg - cfs_pkg::CNT_W'(1);

        store_req.addr  = addr_sum[cfs_pkg::STORE_AW-1:0];
        store_req.wdata = cfs_pkg::WORD_BITS'(in_data.write_word);
        ret_req.wdata   = base_reg;

        unique case (state_reg)
            cfs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    out_data_next.read_word = '0;
                    out_data_next.status    = cfs_pkg::STAT_OK;
                    out_valid_next          = 1'b1;
                    unique case (in_data.func)
                        cfs_pkg::FN_READ:
                        begin
                            if (beyond)
                            begin
                                out_data_next.status = cfs_pkg::STAT_BEYOND;
                            end
                            else
                            begin
                                // result follows once the store answers
                                store_req.re   = 1'b1;
                                out_valid_next = 1'b0;
                                state_next     = cfs_pkg::ST_READ;
                            end
                        end
                        cfs_pkg::FN_WRITE:
                        begin
                            if (beyond)
                            begin
                                out_data_next.status = cfs_pkg::STAT_BEYOND;
                            end
                            else
                            begin
                                store_req.we = 1'b1;
                            end
                        end
                        cfs_pkg::FN_OPEN:
                        begin
                            if (no_fit)
                            begin
                                out_data_next.status = cfs_pkg::STAT_NO_FIT;
                            end
                            else if (count_reg >= cfs_pkg::CNT_W'(cfs_pkg::MAX_NESTING))
                            begin
                                out_data_next.status = cfs_pkg::STAT_RET_FULL;
                            end
                            else
                            begin
                                ret_req.we   = 1'b1;
                                ret_req.addr = count_reg[cfs_pkg::RET_AW-1:0];
                                count_next   = count_reg + cfs_pkg::CNT_W'(1);
                                base_next    = next_base[cfs_pkg::BASE_W-1:0];
                                len_next     = cfs_pkg::BASE_W'(in_data.frame_words);
                            end
                        end
                        cfs_pkg::FN_CLOSE:
                        begin
                            if (count_reg == '0)
                            begin
                                base_next = '0;
                                len_next  = '0;
                            end
                            else
                            begin
                                ret_req.re     = 1'b1;
                                ret_req.addr   = count_dec[cfs_pkg::RET_AW-1:0];
                                count_next     = count_dec;
                                out_valid_next = 1'b0;
                                state_next     = cfs_pkg::ST_POP;
                            end
                        end
                    endcase
                    out_data_next.is_empty = (base_next == '0) && (len_next == '0);
                end
            end
            cfs_pkg::ST_READ:
            begin
                out_data_next.read_word = cfs_pkg::WORD_W'(store_rdata);
                out_data_next.status    = cfs_pkg::STAT_OK;
                out_data_next.is_empty  = (base_reg == '0) && (len_reg == '0);
                out_valid_next          = 1'b1;
                state_next              = cfs_pkg::ST_IDLE;
            end
            cfs_pkg::ST_POP:
            begin
                len_next  = (ret_rdata <= base_reg) ? (base_reg - ret_rdata) : '0;
                base_next = ret_rdata;
                out_data_next.read_word = '0;
                out_data_next.status    = cfs_pkg::STAT_OK;
                out_data_next.is_empty  = (base_next == '0) && (len_next == '0);
                out_valid_next          = 1'b1;
                state_next              = cfs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cfs_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[design/call_frame_stack_core.sv]
// call_frame_stack_core: top level of the call frame stack
// depends on cfs_pkg, cfs_ram, cfs_ctrl
//
// Call frame stack for a virtual machine interpreter. Each input beat reads or
// writes one word at slot_index past the current frame base, opens a frame of
// frame_words words right after the current one (pushing the old base on the
// return stack), or closes the current frame (popping the saved base). Every
// input beat gives exactly one result beat carrying the read word, the empty
// flag after the operation and a status. Writes, opens, rejected operations and
// a close with an empty return stack are answered straight from idle; an
// in-range read and a close that pops a saved base pass through ST_READ or
// ST_POP to wait on the registered read of the word store or return stack ram.
// One item is in flight at a time; the result register lets the next item be
// accepted in the cycle its result is taken. Neither ram is cleared after
// reset; words never written read back as whatever the ram holds.
module call_frame_stack_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cfs_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output cfs_pkg::out_beat_t out_data
);

    // requests from the sequencer to the two rams
    cfs_pkg::store_req_t           store_req;
    cfs_pkg::ret_req_t             ret_req;
    logic [cfs_pkg::WORD_BITS-1:0] store_rdata;
    logic [cfs_pkg::BASE_W-1:0]    ret_rdata;

    // frame registers, sequencer and result register
    cfs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .store_req   (store_req),
        .store_rdata (store_rdata),
        .ret_req     (ret_req),
        .ret_rdata   (ret_rdata)
    );

    // frame word storage
    cfs_ram #(
        .DEPTH (cfs_pkg::STORE_WORDS),
        .WIDTH (cfs_pkg::WORD_BITS)
    ) u_store (
        .clk   (clk),
        .we    (store_req.we),
        .re    (store_req.re),
        .addr  (store_req.addr),
        .wdata (store_req.wdata),
        .rdata (store_rdata)
    );

    // saved frame bases
    cfs_ram #(
        .DEPTH (cfs_pkg::MAX_NESTING),
        .WIDTH (cfs_pkg::BASE_W)
    ) u_ret (
        .clk   (clk),
        .we    (ret_req.we),
        .re    (ret_req.re),
        .addr  (ret_req.addr),
        .wdata (ret_req.wdata),
        .rdata (ret_rdata)
    );

endmodule

[design/cfs_checker.sv]
// cfs_checker: port-level assertions for call_frame_stack_core, with its bind
// depends on cfs_pkg
module cfs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input cfs_pkg::in_beat_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input cfs_pkg::out_beat_t out_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // no new item while a finished result is stuck
    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input ready while result stalled");

    // only a successful read carries data
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != cfs_pkg::STAT_OK |-> out_data.read_word == '0)
        else $error("nonzero read word on failed operation");

    // writes and opens answer in the next cycle with no data
    a_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready &&
        (in_data.func == cfs_pkg::FN_WRITE || in_data.func == cfs_pkg::FN_OPEN)
        |=> out_valid && out_data.read_word == '0)
        else $error("write or open result missing");

endmodule

bind call_frame_stack_core cfs_checker u_cfs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

[tb/tb_call_frame_stack_core.sv]
// tb_call_frame_stack_core: self-checking bench for the call frame stack core
// predicts every result beat from its own frame/return-stack model and checks them in order
// depends on cfs_pkg and call_frame_stack_core
module tb_call_frame_stack_core;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SHOWN_ERRORS = 10;
    localparam int DRAIN_CYCLES = 20;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    cfs_pkg::in_beat_t  in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    cfs_pkg::out_beat_t out_data;

    // predicted state of the frame stack
    logic [cfs_pkg::WORD_BITS-1:0] mem_words [cfs_pkg::STORE_WORDS];
    bit                            mem_written [cfs_pkg::STORE_WORDS];
    int                            ret_bases [cfs_pkg::MAX_NESTING];
    int                            cur_base = 0;
    int                            cur_len = 0;
    int                            ret_depth = 0;

    cfs_pkg::out_beat_t pending_results[$];
    int                 errors = 0;
    int                 cycle_count = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;

    call_frame_stack_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #1 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("call_frame_stack_core test failed");
            $finish;
        end
    end

    // receiver side: random back-pressure at the current stall rate
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker: each taken beat against the oldest prediction
    always @(posedge clk)
    begin
        cfs_pkg::out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= SHOWN_ERRORS)
                    $display("unexpected result beat: read_word=%h is_empty=%0d status=%0d",
                             out_data.read_word, out_data.is_empty, out_data.status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.read_word !== want.read_word ||
                    out_data.is_empty !== want.is_empty ||
                    out_data.status !== want.status)
                begin
                    errors++;
                    if (errors <= SHOWN_ERRORS)
                        $display({"mismatch: expected read_word=%h is_empty=%0d status=%0d,",
                                  " got read_word=%h is_empty=%0d status=%0d"},
                                 want.read_word, want.is_empty, want.status,
                                 out_data.read_word, out_data.is_empty, out_data.status);
                end
            end
        end
    end

    // frame stack behavior for one operation, updates the predicted state
    function automatic cfs_pkg::out_beat_t apply_frame_op(cfs_pkg::in_beat_t op);
        cfs_pkg::out_beat_t r;
        int addr;
        int next_base;
        r.read_word = '0;
        r.status = cfs_pkg::STAT_OK;
        addr = cur_base + int'(op.slot_index);
        case (op.func)
            cfs_pkg::FN_READ, cfs_pkg::FN_WRITE:
            begin
                if (addr >= cfs_pkg::STORE_WORDS)
                    r.status = cfs_pkg::STAT_BEYOND;
                else if (op.func == cfs_pkg::FN_READ)
                    r.read_word = mem_words[addr];
                else
                begin
                    mem_words[addr] = op.write_word[cfs_pkg::WORD_BITS-1:0];
                    mem_written[addr] = 1'b1;
                end
            end
            cfs_pkg::FN_OPEN:
            begin
                next_base = cur_base + cur_len;
                // fit check comes ahead of the nesting check
                if (next_base + int'(op.frame_words) > cfs_pkg::STORE_WORDS)
                    r.status = cfs_pkg::STAT_NO_FIT;
                else if (ret_depth >= cfs_pkg::MAX_NESTING)
                    r.status = cfs_pkg::STAT_RET_FULL;
                else
                begin
                    ret_bases[ret_depth] = cur_base;
                    ret_depth++;
                    cur_base = next_base;
                    cur_len = int'(op.frame_words);
                end
            end
            default:
            begin
                if (ret_depth == 0)
                begin
                    cur_base = 0;
                    cur_len = 0;
                end
                else
                begin
                    ret_depth--;
                    cur_len = (ret_bases[ret_depth] <= cur_base) ?
                              cur_base - ret_bases[ret_depth] : 0;
                    cur_base = ret_bases[ret_depth];
                end
            end
        endcase
        r.is_empty = (cur_base == 0 && cur_len == 0);
        return r;
    endfunction

    function automatic cfs_pkg::in_beat_t make_op(cfs_pkg::func_t f, int slot,
                                                  logic [cfs_pkg::WORD_W-1:0] word,
                                                  int frames);
        cfs_pkg::in_beat_t op;
        op.func = f;
        op.slot_index = cfs_pkg::SLOT_W'(slot);
        op.write_word = word;
        op.frame_words = cfs_pkg::FRAME_W'(frames);
        return op;
    endfunction

    // slot mostly inside the current frame, sometimes anywhere
    function automatic int random_slot();
        if (cur_len > 0 && $urandom_range(99) < 75)
            return $urandom_range(0, cur_len - 1);
        return $urandom_range(0, 1023);
    endfunction

    // a read slot that lands on a written word or past the store end
    function automatic bit find_read_slot(output int slot);
        int cand;
        for (int i = 0; i < 16; i++)
        begin
            cand = random_slot();
            if (cur_base + cand >= cfs_pkg::STORE_WORDS || mem_written[cur_base + cand])
            begin
                slot = cand;
                return 1'b1;
            end
        end
        slot = 0;
        return 1'b0;
    endfunction

    function automatic int random_frame_words();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return $urandom_range(0, 16);
        if (pick < 92)
            return $urandom_range(0, 256);
        if (pick < 97)
            return 1024;
        return $urandom_range(0, 1024);
    endfunction

    function automatic cfs_pkg::in_beat_t random_op();
        cfs_pkg::in_beat_t op;
        int pick;
        int slot;
        op = make_op(cfs_pkg::FN_WRITE, random_slot(), $urandom, $urandom_range(0, 1024));
        pick = $urandom_range(99);
        if (pick >= 35 && pick < 70)
        begin
            // fall back to a write when no legal read is at hand
            if (find_read_slot(slot))
            begin
                op.func = cfs_pkg::FN_READ;
                op.slot_index = cfs_pkg::SLOT_W'(slot);
            end
        end
        else if (pick >= 70 && pick < 86)
        begin
            op.func = cfs_pkg::FN_OPEN;
            op.frame_words = cfs_pkg::FRAME_W'(random_frame_words());
        end
        else if (pick >= 86)
            op.func = cfs_pkg::FN_CLOSE;
        return op;
    endfunction

    // one input beat: random gap, hold valid until taken, then predict
    task automatic send_frame_op(cfs_pkg::in_beat_t op);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= op;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(apply_frame_op(op));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // boundary cases: store ends, frame fit limits, empty closes
    task automatic test_directed_edges();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // close with nothing saved
        send_frame_op(make_op(cfs_pkg::FN_CLOSE, 0, '0, 0));
        send_frame_op(make_op(cfs_pkg::FN_WRITE, 0, 32'h0000_0000, 0));
        send_frame_op(make_op(cfs_pkg::FN_WRITE, 1023, 32'hFFFF_FFFF, 0));
        send_frame_op(make_op(cfs_pkg::FN_READ, 1023, '0, 0));
        send_frame_op(make_op(cfs_pkg::FN_READ, 0, '1, 2047));
        send_frame_op(make_op(cfs_pkg::FN_OPEN, 0, '0, 10));
        // ends exactly at store end
        send_frame_op(make_op(cfs_pkg::FN_OPEN, 0, '0, 1014));
        // past store end
        send_frame_op(make_op(cfs_pkg::FN_READ, 1023, '0, 0));
        // past store end, no effect
        send_frame_op(make_op(cfs_pkg::FN_WRITE, 1014, 32'h1234_5678, 0));
        send_frame_op(make_op(cfs_pkg::FN_WRITE, 1013, 32'hA5A5_A5A5, 0));
        // does not fit
        send_frame_op(make_op(cfs_pkg::FN_OPEN, 0, '0, 1));
        // empty frame at store end
        send_frame_op(make_op(cfs_pkg::FN_OPEN, 0, '0, 0));
        send_frame_op(make_op(cfs_pkg::FN_READ, 0, '0, 0));
        send_frame_op(make_op(cfs_pkg::FN_WRITE, 0, 32'h5A5A_5A5A, 0));
        send_frame_op(make_op(cfs_pkg::FN_CLOSE, 0, '0, 0));
        send_frame_op(make_op(cfs_pkg::FN_READ, 1013, '0, 0));
        send_frame_op(make_op(cfs_pkg::FN_CLOSE, 0, '0, 0));
        send_frame_op(make_op(cfs_pkg::FN_CLOSE, 0, '0, 0));
        send_frame_op(make_op(cfs_pkg::FN_CLOSE, 0, '0, 0));
        // whole store in one frame
        send_frame_op(make_op(cfs_pkg::FN_OPEN, 1023, '1, 1024));
        send_frame_op(make_op(cfs_pkg::FN_READ, 1023, '0, 0));
        send_frame_op(make_op(cfs_pkg::FN_OPEN, 0, '0, 0));
        send_frame_op(make_op(cfs_pkg::FN_CLOSE, 0, '0, 0));
        send_frame_op(make_op(cfs_pkg::FN_CLOSE, 0, '0, 0));
    endtask

    // nest to the return stack limit, hit it, then unwind
    task automatic test_nesting_limit(int idle_pct, int stall_pct);
        int size;
        int slot;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        while (ret_depth > 0)
            send_frame_op(make_op(cfs_pkg::FN_CLOSE, $urandom, $urandom,
                                  $urandom_range(0, 1024)));
        send_frame_op(make_op(cfs_pkg::FN_CLOSE, 0, '0, 0));
        for (int i = 0; i < cfs_pkg::MAX_NESTING; i++)
        begin
            size = $urandom_range(1, 8);
            slot = $urandom_range(0, size - 1);
            send_frame_op(make_op(cfs_pkg::FN_OPEN, $urandom, $urandom, size));
            send_frame_op(make_op(cfs_pkg::FN_WRITE, slot, $urandom, 0));
            send_frame_op(make_op(cfs_pkg::FN_READ, slot, $urandom, 0));
        end
        // return stack full
        send_frame_op(make_op(cfs_pkg::FN_OPEN, 0, '0, 1));
        // no-fit wins over full
        send_frame_op(make_op(cfs_pkg::FN_OPEN, 0, '0, 1024));
        for (int i = 0; i < cfs_pkg::MAX_NESTING; i++)
        begin
            send_frame_op(make_op(cfs_pkg::FN_CLOSE, $urandom, $urandom, 0));
            if (find_read_slot(slot))
                send_frame_op(make_op(cfs_pkg::FN_READ, slot, $urandom, 0));
        end
        send_frame_op(make_op(cfs_pkg::FN_CLOSE, 0, '0, 0));
    endtask

    task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            send_frame_op(random_op());
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_random_traffic(300, 0, 0);
        // hold the sender until everything outstanding has come back
        wait_for_results();
        test_nesting_limit(81, 0);
        test_random_traffic(300, 81, 0);
        test_random_traffic(300, 0, 81);
        test_random_traffic(300, 20, 20);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("call_frame_stack_core test passed");
        else
            $display("call_frame_stack_core test failed");
        $finish;
    end

endmodule

[files.f]
design/cfs_pkg.sv
design/cfs_ram.sv
design/cfs_ctrl.sv
design/call_frame_stack_core.sv
design/cfs_checker.sv
tb/tb_call_frame_stack_core.sv
